>>> hdl/bsfe_pkg.sv
`timescale 1ns / 1ps

package bsfe_pkg;

  // line codes
  localparam logic [7:0] FlagByte = 8'h7E;
  localparam logic [7:0] EscByte  = 8'h7D;
  localparam logic [7:0] EscXor   = 8'h20;

  // fixed slot layout of one run of line bytes
  localparam int unsigned NumSlots   = 6;
  localparam int unsigned SlotOpen   = 0;
  localparam int unsigned SlotPayEsc = 1;
  localparam int unsigned SlotPay    = 2;
  localparam int unsigned SlotChkEsc = 3;
  localparam int unsigned SlotChk    = 4;
  localparam int unsigned SlotClose  = 5;

  // all line bytes caused by one payload beat, present slots marked in mask
  typedef struct packed {
    logic [NumSlots-1:0]      mask;
    logic [NumSlots-1:0][7:0] slot_byte;
  } run_t;

  // byte needs an escape in front of it
  function automatic logic needs_esc(input logic [7:0] b);
    needs_esc = (b == FlagByte) || (b == EscByte);
  endfunction

  // byte as sent after an escape (or unchanged)
  function automatic logic [7:0] esc_value(input logic [7:0] b);
    esc_value = needs_esc(b) ? (b ^ EscXor) : b;
  endfunction

endpackage

>>> hdl/bsfe_in_if.sv
`timescale 1ns / 1ps

interface bsfe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       frame_first;
  logic       frame_last;

  modport source (output valid, output payload_byte, output frame_first,
                  output frame_last, input ready);
  modport sink (input valid, input payload_byte, input frame_first,
                input frame_last, output ready);
endinterface

>>> hdl/bsfe_out_if.sv
`timescale 1ns / 1ps

interface bsfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_byte;
  logic       run_last;
  logic       closing_flag;

  modport source (output valid, output line_byte, output run_last,
                  output closing_flag, input ready);
  modport sink (input valid, input line_byte, input run_last,
                input closing_flag, output ready);
endinterface

>>> hdl/bsfe_run_build.sv
`timescale 1ns / 1ps

module bsfe_run_build (
  input  logic          clk_i,
  input  logic          rst_ni,
  bsfe_in_if.sink       in_i,
  input  logic          run_take_i,
  output logic          run_valid_o,
  output bsfe_pkg::run_t run_o
);

  logic           run_valid_q, run_valid_d;
  bsfe_pkg::run_t run_q, run_d;
  logic [7:0]     check_q, check_d;
  logic [7:0]     check_new;
  logic           accept;

  assign in_i.ready  = !run_valid_q || run_take_i;
  assign accept      = in_i.valid && in_i.ready;
  assign run_valid_o = run_valid_q;
  assign run_o       = run_q;

  // running check, restarted by a first beat
  assign check_new = (in_i.frame_first ? 8'h00 : check_q) ^ in_i.payload_byte;

  // lay out the run of line bytes for this beat
  always_comb begin
    run_d.mask = '0;
    run_d.slot_byte = '0;
    run_d.mask[bsfe_pkg::SlotOpen]        = in_i.frame_first;
    run_d.slot_byte[bsfe_pkg::SlotOpen]   = bsfe_pkg::FlagByte;
    run_d.mask[bsfe_pkg::SlotPayEsc]      = bsfe_pkg::needs_esc(in_i.payload_byte);
    run_d.slot_byte[bsfe_pkg::SlotPayEsc] = bsfe_pkg::EscByte;
    run_d.mask[bsfe_pkg::SlotPay]         = 1'b1;
    run_d.slot_byte[bsfe_pkg::SlotPay]    = bsfe_pkg::esc_value(in_i.payload_byte);
    run_d.mask[bsfe_pkg::SlotChkEsc]      = in_i.frame_last && bsfe_pkg::needs_esc(check_new);
    run_d.slot_byte[bsfe_pkg::SlotChkEsc] = bsfe_pkg::EscByte;
    run_d.mask[bsfe_pkg::SlotChk]         = in_i.frame_last;
    run_d.slot_byte[bsfe_pkg::SlotChk]    = bsfe_pkg::esc_value(check_new);
    run_d.mask[bsfe_pkg::SlotClose]       = in_i.frame_last;
    run_d.slot_byte[bsfe_pkg::SlotClose]  = bsfe_pkg::FlagByte;
  end

  // holding stage control and check state
  always_comb begin
    run_valid_d = run_valid_q;
    check_d     = check_q;
    if (accept) begin
      run_valid_d = 1'b1;
      check_d     = in_i.frame_last ? 8'h00 : check_new;
    end else if (run_take_i) begin
      run_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_valid_q <= 1'b0;
      check_q     <= 8'h00;
    end else begin
      run_valid_q <= run_valid_d;
      check_q     <= check_d;
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      run_q <= run_d;
    end
  end

  // check restarts after every frame end
  a_check_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.frame_last) |=> (check_q == 8'h00))
    else $error("check byte not cleared after frame end");

  // a held run always carries its payload byte
  a_run_has_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_valid_q |-> run_q.mask[bsfe_pkg::SlotPay])
    else $error("held run lacks payload slot");

  // a full holding register that is not drained refuses new beats
  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_valid_q && !run_take_i) |-> !in_i.ready)
    else $error("beat accepted over a held run");

endmodule

>>> hdl/bsfe_serial.sv
`timescale 1ns / 1ps

module bsfe_serial (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           run_valid_i,
  input  bsfe_pkg::run_t run_i,
  output logic           run_take_o,
  bsfe_out_if.source     out_o
);

  logic [bsfe_pkg::NumSlots-1:0]      mask_q, mask_d;
  logic [bsfe_pkg::NumSlots-1:0][7:0] bytes_q;
  logic [bsfe_pkg::NumSlots-1:0]      cur_onehot;
  logic [bsfe_pkg::NumSlots-1:0]      rest;
  logic [7:0]                         sel_byte;
  logic                               take_out;
  logic                               done;

  // lowest pending slot goes out next
  assign cur_onehot = mask_q & (~mask_q + bsfe_pkg::NumSlots'(1));
  assign rest       = mask_q & ~cur_onehot;

  always_comb begin
    sel_byte = 8'h00;
    for (int i = 0; i < bsfe_pkg::NumSlots; i++) begin
      sel_byte = sel_byte | (bytes_q[i] & {8{cur_onehot[i]}});
    end
  end

  assign out_o.valid        = |mask_q;
  assign out_o.line_byte    = sel_byte;
  assign out_o.run_last     = (rest == '0);
  assign out_o.closing_flag = cur_onehot[bsfe_pkg::SlotClose];

  // load the next run once the current one has drained
  assign take_out   = out_o.valid && out_o.ready;
  assign done       = take_out && (rest == '0);
  assign run_take_o = run_valid_i && (!out_o.valid || done);

  always_comb begin
    mask_d = mask_q;
    if (run_take_o) begin
      mask_d = run_i.mask;
    end else if (take_out) begin
      mask_d = rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (run_take_o) begin
      bytes_q <= run_i.slot_byte;
    end
  end

  // closing flag is always the end of its run
  a_close_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.closing_flag) |-> out_o.run_last)
    else $error("closing flag not last of its run");

  // a stalled beat keeps the pending slots
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> $stable(mask_q))
    else $error("pending slots changed under stall");

  // no run is loaded while bytes of the current one remain
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_take_o |-> (!out_o.valid || (take_out && out_o.run_last)))
    else $error("run loaded over a pending run");

endmodule

>>> hdl/byte_stuffing_frame_encoder_top.sv
`timescale 1ns / 1ps

// Byte-stuffing frame encoder with XOR check byte.
// in_i carries one payload byte per beat with frame_first / frame_last marks;
// out_o carries one line byte per beat. A first byte is preceded by a 0x7E
// flag, 0x7E and 0x7D are sent as 0x7D then byte ^ 0x20, and after a last
// byte the stuffed XOR check byte and a closing 0x7E flag follow.
// run_last marks the final line byte caused by one payload beat, and
// closing_flag marks the closing flag of a frame.
// A beat is registered in the holding register and then loaded into the
// serialiser's slot register, from which its first line byte goes out on
// out_o. One payload beat yields one to six line bytes, one per cycle while
// out_o.ready is high, so throughput is set by the output serialiser: one
// payload beat per cycle for plain bytes, lower for escaped bytes and frame
// ends, which yield more line bytes. A holding register in front of the
// serialiser takes the next beat while the current run drains.
// Reset clears the check byte and empties both stages.
// When out_o.ready is low the current line byte holds; once the holding
// register is also full, in_i.ready drops.
module byte_stuffing_frame_encoder_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  bsfe_in_if.sink    in_i,
  bsfe_out_if.source out_o
);

  logic           run_valid;
  logic           run_take;
  bsfe_pkg::run_t run;

  bsfe_run_build u_run_build (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .run_take_i  (run_take),
    .run_valid_o (run_valid),
    .run_o       (run)
  );

  bsfe_serial u_serial (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .run_valid_i (run_valid),
    .run_i       (run),
    .run_take_o  (run_take),
    .out_o       (out_o)
  );

endmodule
